/* hw/rtl/fcte_pkg.sv */
// ----------------------------------------------------------------------------
// fcte_pkg
// Shared types and constants for the FAT32 cluster table engine.
// ----------------------------------------------------------------------------
package fcte_pkg;

    localparam int MAX_CLUSTERS = 4096;
    localparam int MEM_DEPTH    = MAX_CLUSTERS + 2;
    localparam int ADDR_W       = $clog2(MEM_DEPTH);
    localparam int CNT_W        = 13;
    localparam int ENT_W        = 28;
    localparam int FREE_W       = 32;

    localparam logic [ENT_W-1:0]  ENTRY_FREE    = 28'h0000000;
    localparam logic [ENT_W-1:0]  ENTRY_BAD     = 28'hFFFFFF7;
    localparam logic [ENT_W-1:0]  ENTRY_EOC     = 28'hFFFFFF8;
    localparam logic [FREE_W-1:0] COUNT_UNKNOWN = 32'hFFFFFFFF;

    typedef enum logic [2:0] {
        OP_READ    = 3'd0,
        OP_WRITE   = 3'd1,
        OP_ALLOC   = 3'd2,
        OP_FREE    = 3'd3,
        OP_ADVANCE = 3'd4,
        OP_RESCAN  = 3'd5
    } op_code_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_EARLY_END = 3'd2,
        ST_CORRUPT   = 3'd3,
        ST_NO_SPACE  = 3'd4
    } st_code_t;

    typedef enum logic [3:0] {
        C_NONE,
        C_LOAD,
        C_CLEAR,
        C_SET_ST,
        C_RD_DONE,
        C_WRITE,
        C_ALLOC_INIT,
        C_ALLOC_HIT,
        C_ALLOC_MISS,
        C_CNT_CLR,
        C_CNT_INC,
        C_FREE_STEP,
        C_ADV_DEC,
        C_ADV_NEXT,
        C_ADV_END,
        C_RS_INIT
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t  cmd;
        st_code_t st;
        logic     rs_step;
        logic     rs_end;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       in_tab;
        logic       walk_go;
        logic       guard_over;
        logic       alloc_done;
        logic       steps_zero;
        logic       ent_zero;
        logic       ent_eoc;
        logic       ent_bad;
        logic       rs_done;
        logic       clr_done;
    } dp_stat_t;

endpackage

/* hw/rtl/fcte_datapath.sv */
// ----------------------------------------------------------------------------
// fcte_datapath
// Table memory, walk registers, hint, free count and output register.
// ----------------------------------------------------------------------------
module fcte_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fcte_pkg::CNT_W-1:0]     cfg_wdata,
    input  logic [2:0]                     opcode,
    input  logic [fcte_pkg::ENT_W-1:0]     cluster,
    input  logic [fcte_pkg::ENT_W-1:0]     entry_value,
    input  logic [fcte_pkg::CNT_W-1:0]     steps,
    input  fcte_pkg::ctrl_cmd_t            ctl,
    output fcte_pkg::dp_stat_t             stat,
    output logic [2:0]                     status,
    output logic [fcte_pkg::ENT_W-1:0]     result_cluster,
    output logic [fcte_pkg::FREE_W-1:0]    free_total
);

    logic [fcte_pkg::ENT_W-1:0]  mem [fcte_pkg::MEM_DEPTH];
    logic [fcte_pkg::ENT_W-1:0]  mem_q;

    logic [fcte_pkg::CNT_W-1:0]  cc_reg;
    logic [fcte_pkg::ENT_W-1:0]  hint_reg;
    logic [fcte_pkg::FREE_W-1:0] free_reg;
    logic [fcte_pkg::ADDR_W-1:0] clr_idx_reg;

    logic [2:0]                  op_reg;
    logic [fcte_pkg::ENT_W-1:0]  cur_reg;
    logic [fcte_pkg::ENT_W-1:0]  val_reg;
    logic [fcte_pkg::CNT_W-1:0]  steps_reg;
    logic [fcte_pkg::CNT_W-1:0]  cnt_reg;
    logic [fcte_pkg::CNT_W-1:0]  first_reg;
    logic                        have_reg;
    logic [2:0]                  st_reg;
    logic [fcte_pkg::ENT_W-1:0]  res_reg;

    logic [2:0]                  out_st_reg;
    logic [fcte_pkg::ENT_W-1:0]  out_res_reg;
    logic [fcte_pkg::FREE_W-1:0] out_free_reg;

    logic [fcte_pkg::CNT_W-1:0]  n_eff;
    logic [fcte_pkg::CNT_W-1:0]  top;
    logic [fcte_pkg::ENT_W-1:0]  top_x;
    logic [fcte_pkg::ENT_W-1:0]  cur_inc;
    logic [fcte_pkg::ENT_W-1:0]  cur_wrap;
    logic                        hint_ok;
    logic                        free_known;

    logic                        mem_we;
    logic [fcte_pkg::ADDR_W-1:0] mem_waddr;
    logic [fcte_pkg::ENT_W-1:0]  mem_wdata;

    assign n_eff = (cc_reg > fcte_pkg::CNT_W'(fcte_pkg::MAX_CLUSTERS))
                 ? fcte_pkg::CNT_W'(fcte_pkg::MAX_CLUSTERS) : cc_reg;
    assign top        = n_eff + 13'd1;
    assign top_x      = fcte_pkg::ENT_W'(top);
    assign cur_inc    = cur_reg + 28'd1;
    assign cur_wrap   = (cur_inc > top_x) ? 28'd2 : cur_inc;
    assign hint_ok    = (hint_reg >= 28'd2) && (hint_reg <= top_x);
    assign free_known = (free_reg != fcte_pkg::COUNT_UNKNOWN);

    always_comb
    begin
        stat.op         = op_reg;
        stat.in_tab     = (cur_reg != 28'd0) && (cur_reg <= top_x);
        stat.walk_go    = (cur_reg >= 28'd2) && (cur_reg < fcte_pkg::ENTRY_EOC);
        stat.guard_over = (cnt_reg >= n_eff + 13'd2);
        stat.alloc_done = (cnt_reg == n_eff);
        stat.steps_zero = (steps_reg == '0);
        stat.ent_zero   = (mem_q == fcte_pkg::ENTRY_FREE);
        stat.ent_eoc    = (mem_q >= fcte_pkg::ENTRY_EOC);
        stat.ent_bad    = (mem_q == fcte_pkg::ENTRY_BAD);
        stat.rs_done    = (cur_reg > top_x);
        stat.clr_done   = (clr_idx_reg == fcte_pkg::ADDR_W'(fcte_pkg::MEM_DEPTH - 1));
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_reg[fcte_pkg::ADDR_W-1:0];
        mem_wdata = val_reg;
        unique case (ctl.cmd)
            fcte_pkg::C_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = fcte_pkg::ENTRY_FREE;
            end
            fcte_pkg::C_WRITE:     mem_we = 1'b1;
            fcte_pkg::C_ALLOC_HIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = fcte_pkg::ENTRY_EOC;
            end
            fcte_pkg::C_FREE_STEP:
            begin
                mem_we    = 1'b1;
                mem_wdata = fcte_pkg::ENTRY_FREE;
            end
            default: mem_we = 1'b0;
        endcase
    end

    // Table store: one write, one registered read at the walk cursor.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_q <= mem[cur_reg[fcte_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg      <= 13'd4096;
            hint_reg    <= 28'd2;
            free_reg    <= fcte_pkg::COUNT_UNKNOWN;
            clr_idx_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                cc_reg <= cfg_wdata;
            if (ctl.cmd == fcte_pkg::C_CLEAR)
                clr_idx_reg <= clr_idx_reg + 1'b1;
            if (ctl.cmd == fcte_pkg::C_ALLOC_HIT)
            begin
                hint_reg <= cur_wrap;
                if (free_known && (free_reg != '0))
                    free_reg <= free_reg - 32'd1;
            end
            if ((ctl.cmd == fcte_pkg::C_FREE_STEP) && free_known)
                free_reg <= free_reg + 32'd1;
            if (ctl.rs_end)
            begin
                free_reg <= fcte_pkg::FREE_W'(cnt_reg);
                hint_reg <= have_reg ? fcte_pkg::ENT_W'(first_reg) : 28'd2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctl.cmd)
            fcte_pkg::C_LOAD:
            begin
                op_reg    <= opcode;
                cur_reg   <= cluster;
                val_reg   <= entry_value;
                steps_reg <= steps;
                st_reg    <= fcte_pkg::ST_OK;
                res_reg   <= '0;
            end
            fcte_pkg::C_SET_ST:  st_reg  <= ctl.st;
            fcte_pkg::C_RD_DONE: res_reg <= mem_q;
            fcte_pkg::C_ALLOC_INIT:
            begin
                cur_reg <= hint_ok ? hint_reg : 28'd2;
                cnt_reg <= '0;
            end
            fcte_pkg::C_ALLOC_HIT:  res_reg <= cur_reg;
            fcte_pkg::C_ALLOC_MISS:
            begin
                cur_reg <= cur_wrap;
                cnt_reg <= cnt_reg + 13'd1;
            end
            fcte_pkg::C_CNT_CLR:   cnt_reg   <= '0;
            fcte_pkg::C_CNT_INC:   cnt_reg   <= cnt_reg + 13'd1;
            fcte_pkg::C_FREE_STEP: cur_reg   <= mem_q;
            fcte_pkg::C_ADV_DEC:   steps_reg <= steps_reg - 13'd1;
            fcte_pkg::C_ADV_NEXT:  cur_reg   <= mem_q;
            fcte_pkg::C_ADV_END:
            begin
                st_reg  <= ctl.st;
                res_reg <= cur_reg;
            end
            fcte_pkg::C_RS_INIT:
            begin
                cur_reg  <= 28'd2;
                cnt_reg  <= '0;
                have_reg <= 1'b0;
            end
            default: ;
        endcase
        if (ctl.rs_step)
        begin
            cur_reg <= cur_inc;
            if (mem_q == fcte_pkg::ENTRY_FREE)
            begin
                cnt_reg <= cnt_reg + 13'd1;
                if (!have_reg)
                begin
                    first_reg <= cur_reg[fcte_pkg::CNT_W-1:0];
                    have_reg  <= 1'b1;
                end
            end
        end
        if (ctl.rs_end)
            res_reg <= have_reg ? fcte_pkg::ENT_W'(first_reg) : 28'd2;
        if (ctl.out_load)
        begin
            out_st_reg   <= st_reg;
            out_res_reg  <= res_reg;
            out_free_reg <= free_reg;
        end
    end

    assign status         = out_st_reg;
    assign result_cluster = out_res_reg;
    assign free_total     = out_free_reg;

endmodule

/* hw/rtl/fcte_ctrl.sv */
// ----------------------------------------------------------------------------
// fcte_ctrl
// Sequencer: clear pass, per-opcode walks and output handshake.
// ----------------------------------------------------------------------------
module fcte_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  fcte_pkg::dp_stat_t  stat,
    output fcte_pkg::ctrl_cmd_t ctl
);

    typedef enum logic [12:0] {
        S_CLEAR    = 13'b0000000000001,
        S_IDLE     = 13'b0000000000010,
        S_EXEC     = 13'b0000000000100,
        S_RD_WAIT  = 13'b0000000001000,
        S_AL_RD    = 13'b0000000010000,
        S_AL_TEST  = 13'b0000000100000,
        S_FR_CHK   = 13'b0000001000000,
        S_FR_TEST  = 13'b0000010000000,
        S_ADV_CHK  = 13'b0000100000000,
        S_ADV_TEST = 13'b0001000000000,
        S_RS_RD    = 13'b0010000000000,
        S_RS_TEST  = 13'b0100000000000,
        S_FINISH   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        ctl.cmd      = fcte_pkg::C_NONE;
        ctl.st       = fcte_pkg::ST_OK;
        ctl.rs_step  = 1'b0;
        ctl.rs_end   = 1'b0;
        ctl.out_load = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.cmd = fcte_pkg::C_CLEAR;
                if (stat.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.cmd    = fcte_pkg::C_LOAD;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FINISH;
                unique case (stat.op)
                    fcte_pkg::OP_READ:
                    begin
                        if (stat.in_tab)
                            state_next = S_RD_WAIT;
                        else
                        begin
                            ctl.cmd = fcte_pkg::C_SET_ST;
                            ctl.st  = fcte_pkg::ST_INVALID;
                        end
                    end
                    fcte_pkg::OP_WRITE:
                    begin
                        if (stat.in_tab)
                            ctl.cmd = fcte_pkg::C_WRITE;
                        else
                        begin
                            ctl.cmd = fcte_pkg::C_SET_ST;
                            ctl.st  = fcte_pkg::ST_INVALID;
                        end
                    end
                    fcte_pkg::OP_ALLOC:
                    begin
                        ctl.cmd    = fcte_pkg::C_ALLOC_INIT;
                        state_next = S_AL_RD;
                    end
                    fcte_pkg::OP_FREE:
                    begin
                        ctl.cmd    = fcte_pkg::C_CNT_CLR;
                        state_next = S_FR_CHK;
                    end
                    fcte_pkg::OP_ADVANCE: state_next = S_ADV_CHK;
                    fcte_pkg::OP_RESCAN:
                    begin
                        ctl.cmd    = fcte_pkg::C_RS_INIT;
                        state_next = S_RS_RD;
                    end
                    default: state_next = S_FINISH;
                endcase
            end
            S_RD_WAIT:
            begin
                ctl.cmd    = fcte_pkg::C_RD_DONE;
                state_next = S_FINISH;
            end
            S_AL_RD:
            begin
                if (stat.alloc_done)
                begin
                    ctl.cmd    = fcte_pkg::C_SET_ST;
                    ctl.st     = fcte_pkg::ST_NO_SPACE;
                    state_next = S_FINISH;
                end
                else
                    state_next = S_AL_TEST;
            end
            S_AL_TEST:
            begin
                if (stat.ent_zero)
                begin
                    ctl.cmd    = fcte_pkg::C_ALLOC_HIT;
                    state_next = S_FINISH;
                end
                else
                begin
                    ctl.cmd    = fcte_pkg::C_ALLOC_MISS;
                    state_next = S_AL_RD;
                end
            end
            S_FR_CHK:
            begin
                priority if (!stat.walk_go)
                    state_next = S_FINISH;
                else if (stat.guard_over)
                begin
                    ctl.cmd    = fcte_pkg::C_SET_ST;
                    ctl.st     = fcte_pkg::ST_CORRUPT;
                    state_next = S_FINISH;
                end
                else if (!stat.in_tab)
                begin
                    ctl.cmd    = fcte_pkg::C_SET_ST;
                    ctl.st     = fcte_pkg::ST_INVALID;
                    state_next = S_FINISH;
                end
                else
                begin
                    ctl.cmd    = fcte_pkg::C_CNT_INC;
                    state_next = S_FR_TEST;
                end
            end
            S_FR_TEST:
            begin
                ctl.cmd    = fcte_pkg::C_FREE_STEP;
                state_next = S_FR_CHK;
            end
            S_ADV_CHK:
            begin
                priority if (stat.steps_zero)
                begin
                    ctl.cmd    = fcte_pkg::C_ADV_END;
                    state_next = S_FINISH;
                end
                else if (!stat.in_tab)
                begin
                    ctl.cmd    = fcte_pkg::C_ADV_END;
                    ctl.st     = fcte_pkg::ST_INVALID;
                    state_next = S_FINISH;
                end
                else
                begin
                    ctl.cmd    = fcte_pkg::C_ADV_DEC;
                    state_next = S_ADV_TEST;
                end
            end
            S_ADV_TEST:
            begin
                priority if (stat.ent_eoc)
                begin
                    ctl.cmd    = fcte_pkg::C_ADV_END;
                    ctl.st     = fcte_pkg::ST_EARLY_END;
                    state_next = S_FINISH;
                end
                else if (stat.ent_zero || stat.ent_bad)
                begin
                    ctl.cmd    = fcte_pkg::C_ADV_END;
                    ctl.st     = fcte_pkg::ST_CORRUPT;
                    state_next = S_FINISH;
                end
                else
                begin
                    ctl.cmd    = fcte_pkg::C_ADV_NEXT;
                    state_next = S_ADV_CHK;
                end
            end
            S_RS_RD:
            begin
                if (stat.rs_done)
                begin
                    ctl.rs_end = 1'b1;
                    state_next = S_FINISH;
                end
                else
                    state_next = S_RS_TEST;
            end
            S_RS_TEST:
            begin
                ctl.rs_step = 1'b1;
                state_next  = S_RS_RD;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hw/rtl/fat_cluster_table_engine.sv */
// ----------------------------------------------------------------------------
// fat_cluster_table_engine
// FAT32 cluster table with next-fit allocator, chain walk, free and rescan.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries opcode, cluster, entry_value
//   and steps; each transaction yields one output transaction (status,
//   result_cluster, free_total) on out_valid/out_stall. One item is worked
//   at a time; in_stall is high from acceptance until the result is
//   loaded into the output register.
//   Each walk step waits for a registered read of the table memory. Allocate
//   examines one entry per step until it finds a free one (every entry up
//   to the cluster count when there is no space), free and advance take
//   one step per link, and rescan takes one step per cluster.
//   The output register holds a result while out_stall is high; the next
//   item is accepted and worked meanwhile and waits at its end.
//   After reset the table is cleared, one entry per cycle, all 4098 entries,
//   with in_stall high. cluster_count must be written through cfg_we/cfg_wdata
//   only while the block is idle, which the block does not enforce; it resets to 4096.
// ----------------------------------------------------------------------------
module fat_cluster_table_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [fcte_pkg::CNT_W-1:0]  cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  opcode,
    input  logic [fcte_pkg::ENT_W-1:0]  cluster,
    input  logic [fcte_pkg::ENT_W-1:0]  entry_value,
    input  logic [fcte_pkg::CNT_W-1:0]  steps,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [2:0]                  status,
    output logic [fcte_pkg::ENT_W-1:0]  result_cluster,
    output logic [fcte_pkg::FREE_W-1:0] free_total
);

    fcte_pkg::ctrl_cmd_t ctl;
    fcte_pkg::dp_stat_t  stat;

    fcte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    fcte_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .opcode         (opcode),
        .cluster        (cluster),
        .entry_value    (entry_value),
        .steps          (steps),
        .ctl            (ctl),
        .stat           (stat),
        .status         (status),
        .result_cluster (result_cluster),
        .free_total     (free_total)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("accepted a transaction while busy");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!out_valid || !out_stall))
        else $error("output register overwritten while stalled");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= 3'd4))
        else $error("illegal status code");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(result_cluster) && $stable(free_total)))
        else $error("stalled result changed");
`endif

endmodule
